[hdl/pgu_pkg.sv]
// ----------------------------------------------------------------------------
// pgu_pkg
// Types, constants and helper functions shared by the particle gravity
// update pipeline.
// ----------------------------------------------------------------------------
package pgu_pkg;

   localparam int SQRT_STAGES = 8;
   localparam int SQRT_STEPS  = 4;
   localparam int ROOT_BITS   = SQRT_STAGES * SQRT_STEPS;
   localparam int QUOT_BITS   = 17;
   localparam int DIV_STEPS   = 4;
   localparam int DIV_STAGES  = (QUOT_BITS + DIV_STEPS - 1) / DIV_STEPS;

   localparam logic CSR_GRAVITY_X = 1'b0;
   localparam logic CSR_GRAVITY_Y = 1'b1;

   typedef struct packed {
      logic [16:0]        time_step;
      logic [63:0]        position;
      logic [63:0]        velocity;
      logic [63:0]        accelerations;
      logic signed [31:0] life_left;
      logic [63:0]        colour;
      logic [63:0]        colour_rate;
      logic [63:0]        size_pair;
      logic [63:0]        rotation_pair;
   } req_type;

   typedef struct packed {
      logic               alive;
      logic [63:0]        new_position;
      logic [63:0]        new_velocity;
      logic signed [31:0] new_life;
      logic [63:0]        new_colour;
      logic [30:0]        new_size;
      logic signed [31:0] new_rotation;
   } rsp_type;

   typedef struct packed {
      logic               alive;
      logic signed [31:0] life;
      logic [16:0]        time_step;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [31:0] ar;
      logic signed [31:0] at;
      logic [63:0]        colour;
      logic [30:0]        size;
      logic [31:0]        rotation;
      logic               zero;
      logic               exact;
   } side_type;

   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > 40'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -40'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

[hdl/pgu_isqrt.sv]
// ----------------------------------------------------------------------------
// pgu_isqrt
// Pipelined integer square root of a 64-bit value, a few root bits per stage.
// ----------------------------------------------------------------------------
module pgu_isqrt (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] radicand,
   output logic [31:0] root
);

   logic [63:0] v_ff [pgu_pkg::SQRT_STAGES];
   logic [63:0] r_ff [pgu_pkg::SQRT_STAGES];
   logic [63:0] v_in [pgu_pkg::SQRT_STAGES];
   logic [63:0] r_in [pgu_pkg::SQRT_STAGES];

   always_comb begin
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] bitv;
      for (int g = 0; g < pgu_pkg::SQRT_STAGES; g++) begin
         if (g == 0) begin
            v = radicand;
            r = '0;
         end else begin
            v = v_ff[g-1];
            r = r_ff[g-1];
         end
         for (int j = 0; j < pgu_pkg::SQRT_STEPS; j++) begin
            bitv = 64'd1 << (2 * (pgu_pkg::ROOT_BITS - 1 - (g * pgu_pkg::SQRT_STEPS + j)));
            if (v >= r + bitv) begin
               v = v - (r + bitv);
               r = (r >> 1) + bitv;
            end else begin
               r = r >> 1;
            end
         end
         v_in[g] = v;
         r_in[g] = r;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int g = 0; g < pgu_pkg::SQRT_STAGES; g++) begin
            v_ff[g] <= v_in[g];
            r_ff[g] <= r_in[g];
         end
      end
   end

   assign root = r_ff[pgu_pkg::SQRT_STAGES-1][31:0];

endmodule

[hdl/pgu_divide.sv]
// ----------------------------------------------------------------------------
// pgu_divide
// Pipelined restoring divider: two signed Q16.16 numerators scaled by 2^16
// over one shared root, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module pgu_divide (
   input  logic               clock,
   input  logic               en,
   input  logic signed [31:0] num_x,
   input  logic signed [31:0] num_y,
   input  logic [31:0]        den,
   output logic signed [17:0] quot_x,
   output logic signed [17:0] quot_y
);

   localparam int NS = pgu_pkg::DIV_STAGES;
   localparam int QB = pgu_pkg::QUOT_BITS;

   logic [47:0]   rx_ff [NS];
   logic [47:0]   ry_ff [NS];
   logic [QB-1:0] qx_ff [NS];
   logic [QB-1:0] qy_ff [NS];
   logic [31:0]   d_ff  [NS];
   logic          nx_ff [NS];
   logic          ny_ff [NS];
   logic [47:0]   rx_in [NS];
   logic [47:0]   ry_in [NS];
   logic [QB-1:0] qx_in [NS];
   logic [QB-1:0] qy_in [NS];
   logic [31:0]   d_in  [NS];
   logic          nx_in [NS];
   logic          ny_in [NS];

   always_comb begin
      logic [47:0]   rx;
      logic [47:0]   ry;
      logic [QB-1:0] qx;
      logic [QB-1:0] qy;
      logic [31:0]   d;
      logic          nx;
      logic          ny;
      logic [48:0]   t;
      int            k;
      int            i;
      for (int g = 0; g < NS; g++) begin
         if (g == 0) begin
            nx = num_x[31];
            ny = num_y[31];
            rx = {(nx ? 32'(-num_x) : 32'(num_x)), 16'd0};
            ry = {(ny ? 32'(-num_y) : 32'(num_y)), 16'd0};
            qx = '0;
            qy = '0;
            d  = den;
         end else begin
            rx = rx_ff[g-1];
            ry = ry_ff[g-1];
            qx = qx_ff[g-1];
            qy = qy_ff[g-1];
            d  = d_ff[g-1];
            nx = nx_ff[g-1];
            ny = ny_ff[g-1];
         end
         for (int j = 0; j < pgu_pkg::DIV_STEPS; j++) begin
            k = g * pgu_pkg::DIV_STEPS + j;
            if (k < QB) begin
               i = QB - 1 - k;
               t = {17'd0, d} << i;
               if ({1'b0, rx} >= t) begin
                  rx = rx - t[47:0];
                  qx[i] = 1'b1;
               end
               if ({1'b0, ry} >= t) begin
                  ry = ry - t[47:0];
                  qy[i] = 1'b1;
               end
            end
         end
         rx_in[g] = rx;
         ry_in[g] = ry;
         qx_in[g] = qx;
         qy_in[g] = qy;
         d_in[g]  = d;
         nx_in[g] = nx;
         ny_in[g] = ny;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int g = 0; g < NS; g++) begin
            rx_ff[g] <= rx_in[g];
            ry_ff[g] <= ry_in[g];
            qx_ff[g] <= qx_in[g];
            qy_ff[g] <= qy_in[g];
            d_ff[g]  <= d_in[g];
            nx_ff[g] <= nx_in[g];
            ny_ff[g] <= ny_in[g];
         end
      end
   end

   assign quot_x = nx_ff[NS-1] ? -$signed({1'b0, qx_ff[NS-1]}) : $signed({1'b0, qx_ff[NS-1]});
   assign quot_y = ny_ff[NS-1] ? -$signed({1'b0, qy_ff[NS-1]}) : $signed({1'b0, qy_ff[NS-1]});

endmodule

[hdl/particle_gravity_update_core.sv]
// ----------------------------------------------------------------------------
// particle_gravity_update_core
// Gravity-mode particle step in Q16.16: life, radial and tangential
// acceleration plus gravity, semi-implicit integration, colour, size, rotation.
// ----------------------------------------------------------------------------
// The core takes one particle per clock unless the result port stalls; each
// particle passes through the 8-stage square root and the 5-stage divider
// that form the radial unit vector, followed by the acceleration and
// integration multipliers. A stalled result port freezes the whole
// pipeline in place. Gravity is to be written by the user through the csr_
// port only while the core is idle; the core itself does not enforce this.
module particle_gravity_update_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pgu_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pgu_pkg::rsp_type  rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [31:0]       csr_wdata
);

   localparam int DIV_OUT = pgu_pkg::SQRT_STAGES + pgu_pkg::DIV_STAGES;
   localparam int LAST    = DIV_OUT + 5;

   logic                en;
   logic signed [31:0]  grav_x_ff;
   logic signed [31:0]  grav_y_ff;

   logic                vld1_ff;
   pgu_pkg::side_type   side1_ff;
   pgu_pkg::side_type   side1_in;
   logic [63:0]         sqx_ff;
   logic [63:0]         sqy_ff;
   logic [63:0]         s_ff;
   logic                vld_q [LAST+1];
   pgu_pkg::side_type   side_q [LAST+1];
   pgu_pkg::side_type   side2_in;

   logic [31:0]         root;
   logic signed [17:0]  quot_x;
   logic signed [17:0]  quot_y;
   logic signed [17:0]  ux;
   logic signed [17:0]  uy;

   logic signed [49:0]  prx_ff;
   logic signed [49:0]  ptx_ff;
   logic signed [49:0]  pry_ff;
   logic signed [49:0]  pty_ff;
   logic signed [35:0]  ax_ff;
   logic signed [35:0]  ay_ff;
   logic signed [53:0]  mvx_ff;
   logic signed [53:0]  mvy_ff;
   logic signed [31:0]  vnx_ff;
   logic signed [31:0]  vny_ff;
   logic signed [31:0]  vnx5_ff;
   logic signed [31:0]  vny5_ff;
   logic signed [49:0]  mpx_ff;
   logic signed [49:0]  mpy_ff;

   logic                rsp_valid_ff;
   pgu_pkg::rsp_type    rsp_ff;
   pgu_pkg::rsp_type    rsp_in;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grav_x_ff <= '0;
         grav_y_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            pgu_pkg::CSR_GRAVITY_X: grav_x_ff <= csr_wdata;
            pgu_pkg::CSR_GRAVITY_Y: grav_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // first stage: life, colour, size, rotation, squares
   always_comb begin
      logic signed [17:0] dts;
      logic signed [33:0] ld;
      logic signed [33:0] cp;
      logic signed [34:0] cs;
      logic signed [49:0] sp;
      logic signed [33:0] sz;
      logic signed [49:0] rp;
      logic signed [31:0] rot;
      dts = $signed({1'b0, req_data.time_step});
      ld  = 34'(req_data.life_left) - 34'(dts);
      side1_in           = '0;
      side1_in.life      = pgu_pkg::sat32(40'(ld));
      side1_in.alive     = side1_in.life > 0;
      side1_in.time_step = req_data.time_step;
      side1_in.px        = req_data.position[63:32];
      side1_in.py        = req_data.position[31:0];
      side1_in.vx        = req_data.velocity[63:32];
      side1_in.vy        = req_data.velocity[31:0];
      side1_in.ar        = req_data.accelerations[63:32];
      side1_in.at        = req_data.accelerations[31:0];
      for (int k = 0; k < 4; k++) begin
         cp = $signed(req_data.colour_rate[k*16 +: 16]) * dts;
         cs = $signed({19'd0, req_data.colour[k*16 +: 16]}) + 35'(cp >>> 12);
         if (cs < 0) begin
            side1_in.colour[k*16 +: 16] = 16'd0;
         end else if (cs > 35'sd32768) begin
            side1_in.colour[k*16 +: 16] = 16'h8000;
         end else begin
            side1_in.colour[k*16 +: 16] = cs[15:0];
         end
      end
      sp = $signed(req_data.size_pair[31:0]) * dts;
      sz = 34'($signed(req_data.size_pair[63:32])) + 34'(sp >>> 16);
      if (sz < 0) begin
         side1_in.size = '0;
      end else if (sz > 34'sd2147483647) begin
         side1_in.size = 31'h7fffffff;
      end else begin
         side1_in.size = sz[30:0];
      end
      rp  = $signed(req_data.rotation_pair[31:0]) * dts;
      rot = $signed(req_data.rotation_pair[63:32]) + 32'(rp >>> 16);
      side1_in.rotation = rot;
   end

   always_comb begin
      side2_in       = side1_ff;
      side2_in.zero  = (sqx_ff + sqy_ff) == 64'd0;
      side2_in.exact = (sqx_ff + sqy_ff) == 64'h1_0000_0000;
   end

   always_comb begin
      pgu_pkg::side_type sd;
      sd = side_q[DIV_OUT];
      if (sd.exact) begin
         ux = sd.px[17:0];
         uy = sd.py[17:0];
      end else if (sd.zero) begin
         ux = '0;
         uy = '0;
      end else begin
         ux = quot_x;
         uy = quot_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k <= LAST; k++) begin
            vld_q[k] <= 1'b0;
         end
      end else if (en) begin
         vld1_ff      <= req_valid;
         vld_q[0]     <= vld1_ff;
         for (int k = 1; k <= LAST; k++) begin
            vld_q[k] <= vld_q[k-1];
         end
         rsp_valid_ff <= vld_q[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side1_ff  <= side1_in;
         sqx_ff    <= 64'(side1_in.px) * 64'(side1_in.px);
         sqy_ff    <= 64'(side1_in.py) * 64'(side1_in.py);
         s_ff      <= sqx_ff + sqy_ff;
         side_q[0] <= side2_in;
         for (int k = 1; k <= LAST; k++) begin
            side_q[k] <= side_q[k-1];
         end
         prx_ff  <= ux * side_q[DIV_OUT].ar;
         ptx_ff  <= uy * side_q[DIV_OUT].at;
         pry_ff  <= uy * side_q[DIV_OUT].ar;
         pty_ff  <= ux * side_q[DIV_OUT].at;
         ax_ff   <= 36'(prx_ff >>> 16) + 36'((-ptx_ff) >>> 16) + 36'(grav_x_ff);
         ay_ff   <= 36'(pry_ff >>> 16) + 36'(pty_ff >>> 16) + 36'(grav_y_ff);
         mvx_ff  <= ax_ff * $signed({1'b0, side_q[DIV_OUT+2].time_step});
         mvy_ff  <= ay_ff * $signed({1'b0, side_q[DIV_OUT+2].time_step});
         vnx_ff  <= pgu_pkg::sat32(40'(side_q[DIV_OUT+3].vx) + 40'(mvx_ff >>> 16));
         vny_ff  <= pgu_pkg::sat32(40'(side_q[DIV_OUT+3].vy) + 40'(mvy_ff >>> 16));
         mpx_ff  <= vnx_ff * $signed({1'b0, side_q[DIV_OUT+4].time_step});
         mpy_ff  <= vny_ff * $signed({1'b0, side_q[DIV_OUT+4].time_step});
         vnx5_ff <= vnx_ff;
         vny5_ff <= vny_ff;
         rsp_ff  <= rsp_in;
      end
   end

   always_comb begin
      pgu_pkg::side_type  sd;
      logic signed [31:0] pnx;
      logic signed [31:0] pny;
      sd  = side_q[LAST];
      pnx = pgu_pkg::sat32(40'(sd.px) + 40'(mpx_ff >>> 16));
      pny = pgu_pkg::sat32(40'(sd.py) + 40'(mpy_ff >>> 16));
      rsp_in          = '0;
      rsp_in.new_life = sd.life;
      if (sd.alive) begin
         rsp_in.alive        = 1'b1;
         rsp_in.new_position = {pnx, pny};
         rsp_in.new_velocity = {vnx5_ff, vny5_ff};
         rsp_in.new_colour   = sd.colour;
         rsp_in.new_size     = sd.size;
         rsp_in.new_rotation = sd.rotation;
      end
   end

   pgu_isqrt u_isqrt (
      .clock    (clock),
      .en       (en),
      .radicand (s_ff),
      .root     (root)
   );

   pgu_divide u_divide (
      .clock  (clock),
      .en     (en),
      .num_x  (side_q[pgu_pkg::SQRT_STAGES].px),
      .num_y  (side_q[pgu_pkg::SQRT_STAGES].py),
      .den    (root),
      .quot_x (quot_x),
      .quot_y (quot_y)
   );

`ifndef SYNTHESIS
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> vld1_ff)
      else $error("transfer did not enter the pipeline");
   a_alive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.alive == (rsp_data.new_life > 0)))
      else $error("alive flag disagrees with life");
   a_dead: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.alive) |->
      (rsp_data.new_position == 64'd0 && rsp_data.new_colour == 64'd0))
      else $error("dead particle carries state");
   a_colour: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.new_colour[63:48] <= 16'h8000 &&
      rsp_data.new_colour[47:32] <= 16'h8000 && rsp_data.new_colour[31:16] <= 16'h8000 &&
      rsp_data.new_colour[15:0] <= 16'h8000))
      else $error("colour lane out of range");
`endif

endmodule

[dv/particle_gravity_update_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_gravity_update_core_test
// Self-checking bench for the gravity-mode particle step. Directed particles
// cover the life, unit-vector, saturation and clamp corners; random particles
// follow under several gravity settings, with random idling on both ports and
// one long result back-pressure stretch. Every result is checked field by
// field against a predictor running in Q16.16 fixed point.
// ----------------------------------------------------------------------------
module particle_gravity_update_core_test;

   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 40;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   pgu_pkg::req_type  req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   pgu_pkg::rsp_type  rsp_data;
   logic              csr_we = 1'b0;
   logic              csr_index = pgu_pkg::CSR_GRAVITY_X;
   logic [31:0]       csr_wdata = '0;

   pgu_pkg::req_type pending_particles[$];
   pgu_pkg::rsp_type expected_updates[$];
   longint  gravity_x_now = 0;
   longint  gravity_y_now = 0;
   int      error_count = 0;
   int      particles_sent = 0;
   int      updates_seen = 0;
   int      expired_seen = 0;
   int      gravity_settings = 1;
   int      cycle_count = 0;
   int      stall_cycles = 0;
   logic    calm;

   particle_gravity_update_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   assign calm = (cycle_count >= 1500) && (cycle_count < 2100);

   function automatic longint sx32(input logic [31:0] v);
      return longint'(signed'(v));
   endfunction

   function automatic longint limit32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic pgu_pkg::rsp_type gravity_step(input pgu_pkg::req_type p,
                                                     input longint gx,
                                                     input longint gy);
      longint           dt, px, py, vx, vy, ar, at, life, ux, uy, ax, ay, sz, rot, c, d;
      logic [63:0]      s, rem, root, bit_w, col;
      pgu_pkg::rsp_type o;
      dt   = longint'(p.time_step);
      px   = sx32(p.position[63:32]);
      py   = sx32(p.position[31:0]);
      vx   = sx32(p.velocity[63:32]);
      vy   = sx32(p.velocity[31:0]);
      ar   = sx32(p.accelerations[63:32]);
      at   = sx32(p.accelerations[31:0]);
      life = limit32(sx32(p.life_left) - dt);
      o = '0;
      o.new_life = life[31:0];
      if (life <= 0) return o;
      ux = 0;
      uy = 0;
      s = 64'(px * px) + 64'(py * py);
      if (s == 64'h1_0000_0000) begin
         ux = px;
         uy = py;
      end else if (s != 0) begin
         rem = s;
         root = 0;
         bit_w = 64'd1 << 62;
         while (bit_w > rem) bit_w = bit_w >> 2;
         while (bit_w != 0) begin
            if (rem >= root + bit_w) begin
               rem = rem - (root + bit_w);
               root = (root >> 1) + bit_w;
            end else begin
               root = root >> 1;
            end
            bit_w = bit_w >> 2;
         end
         ux = (px * 65536) / longint'(root);
         uy = (py * 65536) / longint'(root);
      end
      ax = ((ux * ar) >>> 16) + ((-uy * at) >>> 16) + gx;
      ay = ((uy * ar) >>> 16) + ((ux * at) >>> 16) + gy;
      vx = limit32(vx + ((ax * dt) >>> 16));
      vy = limit32(vy + ((ay * dt) >>> 16));
      px = limit32(px + ((vx * dt) >>> 16));
      py = limit32(py + ((vy * dt) >>> 16));
      col = '0;
      for (int k = 0; k < 4; k++) begin
         c = longint'(p.colour[k*16 +: 16]);
         d = longint'(signed'(p.colour_rate[k*16 +: 16]));
         c = c + ((d * dt) >>> 12);
         if (c < 0) c = 0;
         if (c > 32768) c = 32768;
         col[k*16 +: 16] = c[15:0];
      end
      sz = sx32(p.size_pair[63:32]) + ((sx32(p.size_pair[31:0]) * dt) >>> 16);
      if (sz < 0) sz = 0;
      if (sz > 64'sd2147483647) sz = 64'sd2147483647;
      rot = sx32(p.rotation_pair[63:32]) + ((sx32(p.rotation_pair[31:0]) * dt) >>> 16);
      o.alive        = 1'b1;
      o.new_position = {px[31:0], py[31:0]};
      o.new_velocity = {vx[31:0], vy[31:0]};
      o.new_colour   = col;
      o.new_size     = sz[30:0];
      o.new_rotation = rot[31:0];
      return o;
   endfunction

   function automatic logic [31:0] modest_q();
      return 32'($urandom_range(0, 1 << 23)) - 32'(1 << 22);
   endfunction

   function automatic logic [31:0] pick_q();
      return ($urandom_range(0, 2) == 0) ? 32'($urandom) : modest_q();
   endfunction

   function automatic pgu_pkg::req_type random_particle();
      pgu_pkg::req_type p;
      p.time_step = ($urandom_range(0, 9) == 0) ? 17'($urandom_range(65537, 131071))
                                                 : 17'($urandom_range(0, 65536));
      p.position      = {pick_q(), pick_q()};
      p.velocity      = {pick_q(), pick_q()};
      p.accelerations = {pick_q(), pick_q()};
      case ($urandom_range(0, 3))
         0: p.life_left = 32'($urandom);
         1: p.life_left = 32'($urandom_range(0, 131072));
         default: p.life_left = 32'($urandom) & 32'h7fffffff;
      endcase
      for (int k = 0; k < 4; k++) begin
         p.colour[k*16 +: 16] = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                            : 16'($urandom_range(0, 32768));
         p.colour_rate[k*16 +: 16] = 16'($urandom);
      end
      p.size_pair     = {pick_q(), pick_q()};
      p.rotation_pair = {pick_q(), pick_q()};
      return p;
   endfunction

   function automatic pgu_pkg::req_type basic_particle();
      pgu_pkg::req_type p;
      p.time_step     = 17'd1092;
      p.position      = {32'sd655360, -32'sd196608};
      p.velocity      = {32'sd65536, 32'sd32768};
      p.accelerations = {-32'sd131072, 32'sd98304};
      p.life_left     = 32'sd327680;
      p.colour        = {16'd16384, 16'd32768, 16'd0, 16'd20000};
      p.colour_rate   = {16'h0800, 16'hf800, 16'h0400, 16'h0000};
      p.size_pair     = {32'sd65536, -32'sd16384};
      p.rotation_pair = {32'sd205887, 32'sd65536};
      return p;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
   endtask

   task automatic set_gravity(input logic [31:0] gx, input logic [31:0] gy);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= pgu_pkg::CSR_GRAVITY_X;
      csr_wdata <= gx;
      @(posedge clock);
      csr_index <= pgu_pkg::CSR_GRAVITY_Y;
      csr_wdata <= gy;
      @(posedge clock);
      csr_we <= 1'b0;
      gravity_x_now = sx32(gx);
      gravity_y_now = sx32(gy);
      gravity_settings++;
   endtask

   task automatic drain();
      do @(negedge clock);
      while (pending_particles.size() != 0 || req_valid || expected_updates.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_updates.push_back(gravity_step(req_data, gravity_x_now,
                                                    gravity_y_now));
            particles_sent++;
         end
         if (!req_valid || req_ready) begin
            if (pending_particles.size() != 0 && (calm || $urandom_range(0, 99) >= 18)) begin
               req_data <= pending_particles.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   int  hold_left = 0;
   bit  pressure_done = 0;
   always @(posedge clock) begin
      pgu_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            updates_seen++;
            if (!rsp_data.alive) expired_seen++;
            if (expected_updates.size() == 0) begin
               report_mismatch("unexpected transfer", rsp_data.new_position, '0);
            end else begin
               want = expected_updates.pop_front();
               if (rsp_data.alive !== want.alive)
                  report_mismatch("alive", rsp_data.alive, want.alive);
               if (rsp_data.new_position !== want.new_position)
                  report_mismatch("new_position", rsp_data.new_position, want.new_position);
               if (rsp_data.new_velocity !== want.new_velocity)
                  report_mismatch("new_velocity", rsp_data.new_velocity, want.new_velocity);
               if (rsp_data.new_life !== want.new_life)
                  report_mismatch("new_life", rsp_data.new_life, want.new_life);
               if (rsp_data.new_colour !== want.new_colour)
                  report_mismatch("new_colour", rsp_data.new_colour, want.new_colour);
               if (rsp_data.new_size !== want.new_size)
                  report_mismatch("new_size", rsp_data.new_size, want.new_size);
               if (rsp_data.new_rotation !== want.new_rotation)
                  report_mismatch("new_rotation", rsp_data.new_rotation, want.new_rotation);
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!pressure_done && updates_seen >= 400) begin
            // hold off long enough to back the pipeline up into the input
            pressure_done = 1;
            hold_left = 300;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || $urandom_range(0, 99) >= 18;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout after %0d idle cycles", stall_cycles);
         $display("particle_gravity_update_core_test: errors");
         $finish;
      end
   end

   initial begin
      pgu_pkg::req_type p;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      pending_particles.push_back(basic_particle());
      p = basic_particle(); p.life_left = 32'sd1092;                   // expires exactly
      pending_particles.push_back(p);
      p = basic_particle(); p.life_left = 32'sh80000000; p.time_step = 17'd65536;
      pending_particles.push_back(p);                                  // life saturates
      p = basic_particle(); p.life_left = 32'sh7fffffff; p.time_step = 17'd0;
      pending_particles.push_back(p);
      p = basic_particle(); p.time_step = 17'h1ffff;                   // oversized step
      pending_particles.push_back(p);
      p = basic_particle(); p.time_step = 17'd65536;
      pending_particles.push_back(p);
      p = basic_particle(); p.position = '0;                           // at origin
      pending_particles.push_back(p);
      p = basic_particle(); p.position = {32'sd65536, 32'sd0};         // exact unit radius
      pending_particles.push_back(p);
      p = basic_particle(); p.position = {32'sd0, -32'sd65536};
      pending_particles.push_back(p);
      p = basic_particle(); p.position = 64'h00000001_00000000;        // tiny radius
      pending_particles.push_back(p);
      p = basic_particle(); p.time_step = 17'd65536;
      p.position = {32'sh7fffffff, 32'sh80000000};
      p.velocity = {32'sh7fffffff, 32'sh7fffffff};
      p.accelerations = {32'sh7fffffff, 32'sh7fffffff};
      pending_particles.push_back(p);
      p.velocity = {32'sh80000000, 32'sh80000000};
      p.accelerations = {32'sh80000000, 32'sh80000000};
      p.position = {32'sh80000000, 32'sh7fffffff};
      pending_particles.push_back(p);
      p = basic_particle(); p.colour = 64'hffff_8001_0000_7fff;        // lanes out of range
      p.colour_rate = {16'h0000, 16'h0000, 16'h8000, 16'h7fff}; p.time_step = 17'd65536;
      pending_particles.push_back(p);
      p.colour_rate = {16'h7fff, 16'h8000, 16'hffff, 16'h0001};
      pending_particles.push_back(p);
      p = basic_particle(); p.size_pair = {32'sd100, 32'sh80000000};   // size floors
      pending_particles.push_back(p);
      p = basic_particle(); p.time_step = 17'd65536;
      p.size_pair = {32'sh7fffffff, 32'sh7fffffff};                    // size saturates
      p.rotation_pair = {32'sh7fffffff, 32'sh7fffffff};                // rotation wraps
      pending_particles.push_back(p);
      p.rotation_pair = {32'sh80000000, 32'sh80000000};
      p.size_pair = {32'sh80000000, 32'sh80000000};
      pending_particles.push_back(p);
      drain();

      set_gravity(32'h7fffffff, 32'h80000000);
      repeat (4) pending_particles.push_back(basic_particle());
      for (int i = 0; i < 250; i++) pending_particles.push_back(random_particle());
      drain();

      set_gravity(32'h80000000, 32'h7fffffff);
      for (int i = 0; i < 250; i++) pending_particles.push_back(random_particle());
      drain();

      set_gravity(modest_q(), modest_q());
      for (int i = 0; i < 280; i++) pending_particles.push_back(random_particle());
      drain();

      set_gravity(32'($urandom), 32'($urandom));
      for (int i = 0; i < 250; i++) pending_particles.push_back(random_particle());
      drain();

      $display("covered %0d particles, %0d of them expired, over %0d gravity settings",
               particles_sent, expired_seen, gravity_settings);
      $display("with random idling on both ports and one long result stall");
      if (error_count == 0 && expected_updates.size() == 0) begin
         $display("particle_gravity_update_core_test: clean");
      end else begin
         $display("particle_gravity_update_core_test: errors");
      end
      $finish;
   end

endmodule

[particle_gravity_update_core.f]
hdl/pgu_pkg.sv
hdl/pgu_isqrt.sv
hdl/pgu_divide.sv
hdl/particle_gravity_update_core.sv
dv/particle_gravity_update_core_test.sv
